>>> src/mbe_pkg.sv
// Shared types, constants and fixed-point helpers for the Mandelbrot escape-time block.
`default_nettype none

package mbe_pkg;

   localparam int MAX_DIMENSION = 2048;
   localparam int FRACTION_BITS = 28;

   localparam int CFG_W    = 12;
   localparam int PIX_W    = 11;
   localparam int BRIGHT_W = 9;
   localparam int BRIGHT_MAX = 256;

   localparam int DIM_W  = $clog2(MAX_DIMENSION) + 1;
   localparam int SPAN_W = (PIX_W + 1 > DIM_W) ? PIX_W + 1 : DIM_W;
   localparam int DIFF_W = SPAN_W + 1;
   localparam int DIV_W  = DIM_W + 2;
   localparam int REM_W  = DIM_W + 3;
   localparam int CMP_W  = SPAN_W + DIM_W + 4;

   localparam int FX_W   = FRACTION_BITS + 4;
   localparam int PROD_W = 2 * FX_W;
   localparam int Q_W    = FRACTION_BITS + 3;
   localparam int NCELL  = Q_W;
   localparam int CNT_W  = CFG_W + 1;
   localparam int LANES  = 2;

   localparam logic signed [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
   localparam logic signed [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};
   localparam logic [FX_W:0] FX_FOUR = (FX_W+1)'(4) << FRACTION_BITS;
   localparam logic signed [FX_W+1:0] WIDE_MAX = {3'b000, {(FX_W-1){1'b1}}};
   localparam logic signed [FX_W+1:0] WIDE_MIN = {3'b111, {(FX_W-1){1'b0}}};

   localparam logic [1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_MAX_ITERATIONS = 2'd2;

   localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = CFG_W'(1920);
   localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = CFG_W'(1080);
   localparam logic [CFG_W-1:0] RST_MAX_ITERATIONS = CFG_W'(512);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                             valid;
      logic [DIV_W-1:0]                 divisor;
      logic [LANES-1:0]                 neg;
      logic [LANES-1:0]                 sat;
      logic [LANES-1:0][REM_W-1:0]      rem;
      logic [LANES-1:0][Q_W-1:0]        quo;
   } div_type;

   typedef struct packed {
      logic signed [FX_W-1:0] c_re;
      logic signed [FX_W-1:0] c_im;
   } point_type;

   typedef struct packed {
      logic [BRIGHT_W-1:0] brightness;
      logic                escaped;
   } result_type;

   function automatic logic signed [FX_W-1:0] fx_from_prod(input logic [PROD_W-1:0] p,
                                                         input logic neg);
      logic [FX_W-1:0] mag;
      mag = {1'b0, p[FX_W-2+FRACTION_BITS:FRACTION_BITS]};
      if (p[PROD_W-1:FX_W-1+FRACTION_BITS] != '0) begin
         return neg ? FX_MIN : FX_MAX;
      end
      return neg ? $signed(~mag + 1'b1) : $signed(mag);
   endfunction

   function automatic logic signed [FX_W-1:0] fx_sat(input logic signed [FX_W+1:0] v);
      if (v > WIDE_MAX) begin
         return FX_MAX;
      end
      if (v < WIDE_MIN) begin
         return FX_MIN;
      end
      return v[FX_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/mbe_cell.sv
// One restoring-division cell: a quotient bit for both coordinate lanes.
`default_nettype none

module mbe_cell
   import mbe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire div_type din,
   output div_type      dout
);

   div_type stage_ff;
   div_type stage_in;

   always_comb begin
      logic             ge;
      logic [REM_W-1:0] left;
      stage_in = din;
      for (int k = 0; k < LANES; k++) begin
         ge = din.rem[k] >= {1'b0, din.divisor};
         left = ge ? din.rem[k] - {1'b0, din.divisor} : din.rem[k];
         stage_in.rem[k] = {left[REM_W-2:0], 1'b0};
         stage_in.quo[k] = {din.quo[k][Q_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign dout = stage_ff;

endmodule

`default_nettype wire

>>> src/mbe_coord.sv
// Pixel to complex point conversion: setup stage, divider cell chain, sign stage.
`default_nettype none

module mbe_coord
   import mbe_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [PIX_W-1:0] pixel_x,
   input  wire logic [PIX_W-1:0] pixel_y,
   input  wire logic [CFG_W-1:0] image_width,
   input  wire logic [CFG_W-1:0] image_height,
   output logic                  out_valid,
   output point_type             point
);

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [CFG_W+DIM_W-1:0] wide;
      wide = (CFG_W+DIM_W)'(v);
      if (v == '0) begin
         return DIM_W'(1);
      end
      if (wide > (CFG_W+DIM_W)'(MAX_DIMENSION)) begin
         return DIM_W'(MAX_DIMENSION);
      end
      return wide[DIM_W-1:0];
   endfunction

   div_type   chain [0:NCELL];
   div_type   setup_in;
   logic      valid_ff;
   point_type point_ff;
   point_type point_in;

   always_comb begin
      logic [DIM_W-1:0]         w;
      logic [LANES-1:0][PIX_W-1:0] pix;
      logic [LANES-1:0][DIM_W-1:0] dim;
      logic signed [DIFF_W-1:0] diff;
      logic [DIFF_W-1:0]        mag_full;
      logic [CMP_W-1:0]         num;
      logic [CMP_W-1:0]         w8;
      w = clamp_dim(image_width);
      pix[0] = pixel_x;
      pix[1] = pixel_y;
      dim[0] = w;
      dim[1] = clamp_dim(image_height);
      w8 = CMP_W'({w, 3'b000});
      setup_in = '0;
      setup_in.valid = in_valid;
      setup_in.divisor = {w, 2'b00};
      for (int k = 0; k < LANES; k++) begin
         diff = $signed({1'b0, SPAN_W'({pix[k], 1'b0})}) - $signed({1'b0, SPAN_W'(dim[k])});
         mag_full = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
         num = CMP_W'({mag_full[SPAN_W-1:0], 1'b0});
         setup_in.neg[k] = diff[DIFF_W-1];
         setup_in.sat[k] = num >= w8;
         setup_in.rem[k] = (num >= w8) ? '0 : num[REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain[0] <= '0;
      end else begin
         chain[0] <= setup_in;
      end
   end

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      mbe_cell u_cell (
         .clock (clock),
         .reset (reset),
         .din   (chain[g]),
         .dout  (chain[g+1])
      );
   end

   always_comb begin
      logic [FX_W-1:0] mag_re;
      logic [FX_W-1:0] mag_im;
      mag_re = {1'b0, chain[NCELL].quo[0]};
      mag_im = {1'b0, chain[NCELL].quo[1]};
      if (chain[NCELL].sat[0]) begin
         point_in.c_re = chain[NCELL].neg[0] ? FX_MIN : FX_MAX;
      end else begin
         point_in.c_re = chain[NCELL].neg[0] ? $signed(~mag_re + 1'b1) : $signed(mag_re);
      end
      if (chain[NCELL].sat[1]) begin
         point_in.c_im = chain[NCELL].neg[1] ? FX_MIN : FX_MAX;
      end else begin
         point_in.c_im = chain[NCELL].neg[1] ? $signed(~mag_im + 1'b1) : $signed(mag_im);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= chain[NCELL].valid;
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
   end

   assign out_valid = valid_ff;
   assign point = point_ff;

endmodule

`default_nettype wire

>>> src/mbe_iter.sv
// Escape-time iteration engine: z = z*z + c, one multiply phase and one update phase per step.
`default_nettype none

module mbe_iter
   import mbe_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire point_type        point,
   input  wire logic [CFG_W-1:0] limit,
   output logic                  res_valid,
   input  wire logic             res_ready,
   output result_type            result
);

   state_type state_ff, state_in;

   logic signed [FX_W-1:0] x_ff, x_in;
   logic signed [FX_W-1:0] y_ff, y_in;
   logic signed [FX_W-1:0] cr_ff, cr_in;
   logic signed [FX_W-1:0] ci_ff, ci_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [PROD_W-1:0]      pxx_ff, pxx_in;
   logic [PROD_W-1:0]      pyy_ff, pyy_in;
   logic [PROD_W-1:0]      pxy_ff, pxy_in;
   logic                   nxy_ff, nxy_in;
   result_type             result_ff, result_in;

   logic [FX_W-1:0]        ax, ay;
   logic signed [FX_W-1:0] xx, yy, xy;
   logic [FX_W:0]          sq_sum;
   logic                   escape;
   logic [CNT_W-1:0]       count_next;
   logic                   more;
   logic signed [FX_W+1:0] re_wide, im_wide;

   always_comb begin
      ax = x_ff[FX_W-1] ? (~x_ff + 1'b1) : x_ff;
      ay = y_ff[FX_W-1] ? (~y_ff + 1'b1) : y_ff;
      xx = fx_from_prod(pxx_ff, 1'b0);
      yy = fx_from_prod(pyy_ff, 1'b0);
      xy = fx_from_prod(pxy_ff, nxy_ff);
      sq_sum = {1'b0, xx} + {1'b0, yy};
      escape = sq_sum > FX_FOUR;
      count_next = count_ff + 1'b1;
      more = count_next <= {1'b0, limit};
      re_wide = (FX_W+2)'(xx) - (FX_W+2)'(yy) + (FX_W+2)'(cr_ff);
      im_wide = ((FX_W+2)'(xy) <<< 1) + (FX_W+2)'(ci_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (escape || !more) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      cr_in = cr_ff;
      ci_in = ci_ff;
      count_in = count_ff;
      pxx_in = pxx_ff;
      pyy_in = pyy_ff;
      pxy_in = pxy_ff;
      nxy_in = nxy_ff;
      result_in = result_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in = '0;
               y_in = '0;
               count_in = '0;
               cr_in = point.c_re;
               ci_in = point.c_im;
            end
         end
         ST_MUL: begin
            pxx_in = PROD_W'(ax) * PROD_W'(ax);
            pyy_in = PROD_W'(ay) * PROD_W'(ay);
            pxy_in = PROD_W'(ax) * PROD_W'(ay);
            nxy_in = x_ff[FX_W-1] ^ y_ff[FX_W-1];
         end
         ST_UPD: begin
            if (escape) begin
               result_in.escaped = 1'b1;
               result_in.brightness = (count_ff > CNT_W'(BRIGHT_MAX)) ?
                                      BRIGHT_W'(BRIGHT_MAX) : count_ff[BRIGHT_W-1:0];
            end else begin
               x_in = fx_sat(re_wide);
               y_in = fx_sat(im_wide);
               count_in = count_next;
               result_in.escaped = 1'b0;
               result_in.brightness = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      res_valid = state_ff == ST_DONE;
      result = result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      cr_ff <= cr_in;
      ci_ff <= ci_in;
      count_ff <= count_in;
      pxx_ff <= pxx_in;
      pyy_ff <= pyy_in;
      pxy_ff <= pxy_in;
      nxy_ff <= nxy_in;
      result_ff <= result_in;
   end

   // an escape never happens on the first step, so escaped results are nonzero
   a_esc_bright: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && result_ff.escaped |-> result_ff.brightness != '0)
      else $error("escaped result with zero brightness");

   a_inside_dark: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && !result_ff.escaped |-> result_ff.brightness == '0)
      else $error("inside result with nonzero brightness");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ST_IDLE)
      else $error("new point arrived while engine busy");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && !res_ready |=> state_ff == ST_DONE && $stable(result_ff))
      else $error("result dropped before hand-off");

endmodule

`default_nettype wire

>>> src/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time evaluator: stream ports, registers, output stage.
//
// Usage:
//   req_* carries one pixel per beat; rsp_* returns one result beat per pixel, in order.
//   csr_* writes image_width (0), image_height (1) and max_iterations (2); other
//   indexes are ignored. Write only while no pixel is in flight.
//   One pixel is worked on at a time. A beat entering passes the setup stage, the
//   coordinate divider (one cell per quotient bit, 31 cells) and the sign stage,
//   then n iterations of the escape loop (multiply, then update), with n at most
//   max_iterations+1, before the result is written into the output register.
//   req_tready rises again as soon as the result sits in the output register, so the
//   next pixel is taken while the previous result waits for rsp_tready.
//   If the receiver stalls, the result holds in the output register and the loop
//   holds its finished result; nothing is lost.
//   Synchronous active-high reset empties the pipeline and restores register defaults
//   (1920, 1080, 512).
`default_nettype none

module mandelbrot_escape_time
   import mbe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // pixel_x[10:0], pixel_y[21:11], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // brightness[8:0], escaped[9], zero pad
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_wdata
);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [CFG_W-1:0] limit_ff, limit_in;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff, rsp_data_in;

   logic       req_beat;
   logic       coord_valid;
   point_type  point;
   logic       res_valid;
   logic       res_ready;
   result_type result;

   assign req_tready = !busy_ff;
   assign req_beat = req_tvalid && req_tready;
   assign res_ready = !rsp_valid_ff || rsp_tready;

   mbe_coord u_coord (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_beat),
      .pixel_x      (req_tdata[PIX_W-1:0]),
      .pixel_y      (req_tdata[2*PIX_W-1:PIX_W]),
      .image_width  (width_ff),
      .image_height (height_ff),
      .out_valid    (coord_valid),
      .point        (point)
   );

   mbe_iter u_iter (
      .clock     (clock),
      .reset     (reset),
      .start     (coord_valid),
      .point     (point),
      .limit     (limit_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .result    (result)
   );

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      limit_in = limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:    width_in = csr_wdata;
            CSR_IMAGE_HEIGHT:   height_in = csr_wdata;
            CSR_MAX_ITERATIONS: limit_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (req_beat) begin
         busy_in = 1'b1;
      end else if (res_valid && res_ready) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         limit_ff <= RST_MAX_ITERATIONS;
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         limit_ff <= limit_in;
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = 16'({rsp_data_ff.escaped, rsp_data_ff.brightness});

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for mandelbrot_escape_time: directed table, then random pixel phases.
`timescale 1ns / 100ps

module tb
   import mbe_pkg::*;
;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 64;
   localparam int HOLD_CYCLES   = 3000;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int PHASES        = 12;

   localparam logic [1:0] CSR_UNUSED = 2'd3;

   localparam longint FIX_HI   = (longint'(1) << (FRACTION_BITS + 3)) - 1;
   localparam longint FIX_LO   = -FIX_HI - 1;
   localparam longint FIX_FOUR = longint'(4) << FRACTION_BITS;

   typedef enum logic {
      ROW_PIXEL,
      ROW_WRITE
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0] index;
      logic [11:0] value;
      logic [10:0] px;
      logic [10:0] py;
      logic       typed;
      result_type want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;    // pixel_x[10:0], pixel_y[21:11], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // brightness[8:0], escaped[9], zero pad
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [11:0] csr_wdata = '0;

   logic [11:0] cfg_width  = RST_IMAGE_WIDTH;
   logic [11:0] cfg_height = RST_IMAGE_HEIGHT;
   logic [11:0] cfg_iter   = RST_MAX_ITERATIONS;

   result_type pending[$];
   result_type head;
   row_type    plan[$];

   int send_idle_pct = 36;
   int rsp_idle_pct  = 75;
   int hold_req      = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int fails         = 0;
   int items_sent    = 0;
   int beats_checked = 0;
   int settings_run  = 0;
   int cycle_count   = 0;

   mandelbrot_escape_time u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #CLOCK_HALF clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic longint clamp_dim(input logic [11:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIMENSION) return MAX_DIMENSION;
      return longint'(v);
   endfunction

   function automatic longint fix_clip(input longint v);
      if (v > FIX_HI) return FIX_HI;
      if (v < FIX_LO) return FIX_LO;
      return v;
   endfunction

   // exact product, truncated toward zero, saturated
   function automatic longint fix_mul(input longint a, input longint b);
      longint unsigned ma, mb, p;
      logic neg;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p = (ma * mb) >> FRACTION_BITS;
      if (p > FIX_HI) return neg ? FIX_LO : FIX_HI;
      return neg ? -longint'(p) : longint'(p);
   endfunction

   // (2p - d) * 2 / w, rounded toward zero, saturated
   function automatic longint coord_fixed(input longint p, input longint d, input longint w);
      longint diff;
      longint unsigned num, q;
      diff = 2 * p - d;
      num = (diff < 0) ? -diff : diff;
      num = num * 2;
      if (num >= 8 * w) return (diff < 0) ? FIX_LO : FIX_HI;
      q = (num << FRACTION_BITS) / w;
      return (diff < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic result_type escape_of(input logic [10:0] px, input logic [10:0] py);
      longint w, h, lim, n, cr, ci, x, y, xx, yy, xy;
      logic gone;
      result_type r;
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      lim = longint'(cfg_iter);
      cr = coord_fixed(longint'(px), w, w);
      ci = coord_fixed(longint'(py), h, w);
      x = 0;
      y = 0;
      n = 0;
      gone = 1'b0;
      while (n <= lim && !gone) begin
         xx = fix_mul(x, x);
         yy = fix_mul(y, y);
         if (xx + yy > FIX_FOUR) begin
            gone = 1'b1;
         end else begin
            xy = fix_mul(x, y);
            x = fix_clip(xx - yy + cr);
            y = fix_clip(2 * xy + ci);
            n++;
         end
      end
      r.escaped = (n <= lim);
      r.brightness = !r.escaped ? '0 : (n > BRIGHT_MAX) ? BRIGHT_W'(BRIGHT_MAX) : BRIGHT_W'(n);
      return r;
   endfunction

   // ---------------------------------------------------------------- table rows

   function automatic row_type write_row(input logic [1:0] idx, input logic [11:0] val);
      row_type r;
      r = '0;
      r.kind = ROW_WRITE;
      r.index = idx;
      r.value = val;
      return r;
   endfunction

   function automatic row_type pixel_row(input logic [10:0] px, input logic [10:0] py);
      row_type r;
      r = '0;
      r.kind = ROW_PIXEL;
      r.px = px;
      r.py = py;
      return r;
   endfunction

   function automatic row_type pixel_row_is(input logic [10:0] px, input logic [10:0] py,
                                            input logic [8:0] bright, input logic esc);
      row_type r;
      r = pixel_row(px, py);
      r.typed = 1'b1;
      r.want.brightness = bright;
      r.want.escaped = esc;
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_pixel(input logic [10:0] px, input logic [10:0] py,
                             input result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending.push_back(want);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic cfg_write(input logic [1:0] idx, input logic [11:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_IMAGE_WIDTH:    cfg_width = val;
         CSR_IMAGE_HEIGHT:   cfg_height = val;
         CSR_MAX_ITERATIONS: cfg_iter = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------- result side

   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending.size() == 0) begin
            $error("result beat with no pixel outstanding: tdata %h", rsp_tdata);
            fails++;
         end else begin
            head = pending.pop_front();
            beats_checked++;
            if (rsp_tdata[BRIGHT_W-1:0] !== head.brightness) begin
               $error("brightness: expected %0d, got %0d", head.brightness,
                      rsp_tdata[BRIGHT_W-1:0]);
               fails++;
            end
            if (rsp_tdata[BRIGHT_W] !== head.escaped) begin
               $error("escaped: expected %0d, got %0d", head.escaped, rsp_tdata[BRIGHT_W]);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending.size());
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      int unsigned ph, k, n;
      logic [10:0] px, py;
      logic [11:0] w_val, h_val, m_val;

      // reset view: 1920 x 1080, limit 512
      plan.push_back(pixel_row_is(0, 0, 1, 1));
      plan.push_back(pixel_row_is(960, 540, 0, 0));
      plan.push_back(pixel_row_is(2047, 2047, 1, 1));
      plan.push_back(pixel_row(2047, 0));
      plan.push_back(pixel_row(0, 2047));
      plan.push_back(pixel_row(480, 540));
      plan.push_back(pixel_row(1440, 540));
      plan.push_back(pixel_row(1200, 700));
      // zero limit
      plan.push_back(write_row(CSR_MAX_ITERATIONS, 12'd0));
      plan.push_back(pixel_row_is(960, 540, 0, 0));
      plan.push_back(pixel_row_is(0, 0, 0, 0));
      // oversize dimensions, top limit
      plan.push_back(write_row(CSR_MAX_ITERATIONS, 12'hFFF));
      plan.push_back(write_row(CSR_IMAGE_WIDTH, 12'hFFF));
      plan.push_back(write_row(CSR_IMAGE_HEIGHT, 12'hFFF));
      plan.push_back(pixel_row_is(1024, 1024, 0, 0));
      plan.push_back(pixel_row_is(0, 0, 1, 1));
      plan.push_back(pixel_row(2047, 2047));
      // zero dimensions
      plan.push_back(write_row(CSR_MAX_ITERATIONS, 12'd20));
      plan.push_back(write_row(CSR_IMAGE_WIDTH, 12'd0));
      plan.push_back(write_row(CSR_IMAGE_HEIGHT, 12'd0));
      plan.push_back(pixel_row_is(0, 0, 1, 1));
      plan.push_back(pixel_row_is(1, 1, 1, 1));
      plan.push_back(pixel_row(2047, 5));
      // unused register index must leave the settings alone
      plan.push_back(write_row(CSR_IMAGE_WIDTH, 12'd1920));
      plan.push_back(write_row(CSR_IMAGE_HEIGHT, 12'd1080));
      plan.push_back(write_row(CSR_MAX_ITERATIONS, 12'd300));
      plan.push_back(write_row(CSR_UNUSED, 12'hFFF));
      plan.push_back(write_row(CSR_UNUSED, 12'h000));
      plan.push_back(pixel_row(1440, 540));
      plan.push_back(pixel_row(700, 400));
      // pixel outside the image
      plan.push_back(write_row(CSR_IMAGE_WIDTH, 12'd100));
      plan.push_back(write_row(CSR_IMAGE_HEIGHT, 12'd100));
      plan.push_back(pixel_row_is(2047, 1500, 1, 1));
      plan.push_back(pixel_row(150, 20));

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_WRITE) begin
            wait_idle();
            cfg_write(plan[r].index, plan[r].value);
         end else begin
            send_pixel(plan[r].px, plan[r].py,
                       plan[r].typed ? plan[r].want : escape_of(plan[r].px, plan[r].py));
         end
      end

      for (ph = 0; ph < PHASES; ph++) begin
         send_idle_pct = (ph < 4) ? 36 : (ph < 8) ? 75 : 0;
         rsp_idle_pct  = (ph < 4) ? 75 : (ph < 8) ? 36 : 0;
         n = 60;
         w_val = 12'($urandom_range(2048, 16));
         h_val = 12'($urandom_range(2048, 16));
         m_val = 12'($urandom_range(64, 2));
         case (ph)
            0: begin
               w_val = RST_IMAGE_WIDTH;
               h_val = RST_IMAGE_HEIGHT;
               m_val = RST_MAX_ITERATIONS;
               n = 40;
            end
            3: begin
               w_val = 12'($urandom_range(16, 1));
               h_val = 12'($urandom_range(16, 1));
            end
            5: begin
               w_val = 12'($urandom_range(2048, 256));
               h_val = 12'($urandom_range(2048, 256));
               m_val = 12'hFFF;
               n = 8;
            end
            6: m_val = 12'd1;
            7: m_val = 12'($urandom_range(400, 257));
            9: begin
               w_val = 12'hFFF;
               h_val = 12'hFFF;
            end
            10: begin
               w_val = 12'd0;
               h_val = 12'd0;
            end
            default: ;
         endcase
         wait_idle();
         cfg_write(CSR_IMAGE_WIDTH, w_val);
         cfg_write(CSR_IMAGE_HEIGHT, h_val);
         cfg_write(CSR_MAX_ITERATIONS, m_val);
         if ($urandom_range(2) == 0) cfg_write(CSR_UNUSED, 12'($urandom_range(4095)));
         settings_run++;
         if (ph == 8) hold_req++;
         for (k = 0; k < n; k++) begin
            // mostly pixels inside the view, some anywhere
            px = ($urandom_range(4) != 0) ?
                 11'($urandom_range(32'(clamp_dim(cfg_width) - 1))) :
                 11'($urandom_range(2047));
            py = ($urandom_range(4) != 0) ?
                 11'($urandom_range(32'(clamp_dim(cfg_height) - 1))) :
                 11'($urandom_range(2047));
            send_pixel(px, py, escape_of(px, py));
         end
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("%0d pixels sent, %0d results checked, %0d random register settings",
               items_sent, beats_checked, settings_run);
      $display("views: reset, tiny, zero and oversize dimensions; limits 0 to 4095; output hold");
      if (fails == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", fails);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
